[sv/assert_macros.svh]
// assert_macros.svh: concurrent assertion shorthands for the tangent frame rtl
// no dependencies; taken in by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define TFN_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("tfn assertion failed");

// next-cycle implication, off during reset
`define TFN_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("tfn assertion failed");

`endif

[sv/tfn_pkg.sv]
// tfn_pkg: widths, item types, sideband struct and rounding helper
// for the tangent frame pipeline; no dependencies
`default_nettype none

package tfn_pkg;

  localparam int COMP_W   = 16;
  localparam int FRAC_W   = 14;
  localparam int REG_W    = 15;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * COMP_W;
  localparam int RND_W    = PROD_W - FRAC_W;
  localparam int DOT_W    = RND_W + 2;
  localparam int CROSS_W  = RND_W + 1;
  localparam int ABS_W    = CROSS_W - 2;
  localparam int SQ_W     = 2 * ABS_W + 2;
  localparam int MINSQ_W  = 2 * REG_W;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int NUM_W    = ABS_W + FRAC_W + 1;
  localparam int QUO_W    = FRAC_W + 1;

  localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);

  // register map, selected by address bit 2
  localparam logic CFG_SWAP_IDX   = 1'b0;
  localparam logic CFG_MINMAG_IDX = 1'b1;

  localparam logic [REG_W-1:0] SWAP_RESET   = REG_W'(16056);
  localparam logic [REG_W-1:0] MINMAG_RESET = REG_W'(2);

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [2:0][COMP_W-1:0]   vec_t;
  typedef logic [2:0][CROSS_W-1:0]  crossv_t;

  typedef struct packed {
    comp_t ref_a_x;
    comp_t ref_a_y;
    comp_t ref_a_z;
    comp_t ref_b_x;
    comp_t ref_b_y;
    comp_t ref_b_z;
    comp_t normal_x;
    comp_t normal_y;
    comp_t normal_z;
  } tfn_in_t;

  typedef struct packed {
    comp_t tan1_x;
    comp_t tan1_y;
    comp_t tan1_z;
    comp_t tan2_x;
    comp_t tan2_y;
    comp_t tan2_z;
    logic  degenerate;
    logic  used_fallback;
  } tfn_out_t;

  // what travels beside the arithmetic through every stage
  typedef struct packed {
    vec_t nrm;
    vec_t tan1;
    logic fallback;
    logic deg;
  } side_t;

  // product rounded to component scale, half up then floor
  function automatic logic signed [RND_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    t = (PROD_W + 1)'(p) + ROUND_HALF;
    return t[PROD_W-1:FRAC_W];
  endfunction

endpackage

`default_nettype wire

[sv/tangent_frame_from_normal.sv]
// Tangent frame from normal. Takes one item per clock (busy is always low); its result is on
// the out_ ports once the item has passed every stage, marked by out_strobe for one cycle;
// the receiver cannot hold it off. The pipeline holds two passes of cross product (4 stages),
// an 18-stage square root and a 16-stage divider, plus 2 stages for the reference choice
// and one output register.
// Registers: swap_threshold at 0x0, min_magnitude at 0x4, 15 bits each.
// depends on tfn_pkg, tfn_cross, tfn_isqrt, tfn_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tangent_frame_from_normal (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tfn_pkg::tfn_in_t              in_item,
  output logic                          out_strobe,
  output tfn_pkg::tfn_out_t             out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tfn_pkg::ADDR_W-1:0]    paddr,
  input  logic [tfn_pkg::DATA_W-1:0]    pwdata,
  output logic [tfn_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import tfn_pkg::*;

  // configuration registers
  logic [REG_W-1:0]   swap_r, minmag_r;
  logic [MINSQ_W-1:0] minsq_r;
  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r   <= SWAP_RESET;
      minmag_r <= MINMAG_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CFG_SWAP_IDX:   swap_r   <= pwdata[REG_W-1:0];
        CFG_MINMAG_IDX: minmag_r <= pwdata[REG_W-1:0];
        default:        swap_r   <= swap_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    minsq_r <= MINSQ_W'(minmag_r) * MINSQ_W'(minmag_r);
  end

  // register read
  always_comb begin
    unique case (paddr[2])
      CFG_SWAP_IDX:   prdata = DATA_W'(swap_r);
      CFG_MINMAG_IDX: prdata = DATA_W'(minmag_r);
      default:        prdata = '0;
    endcase
  end

  // stage a: dot product terms
  logic                     a_vld_r;
  logic signed [PROD_W-1:0] dp_r [3];
  tfn_in_t                  a_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dp_r[0]  <= PROD_W'($signed(in_item.ref_a_x)) * PROD_W'($signed(in_item.normal_x));
    dp_r[1]  <= PROD_W'($signed(in_item.ref_a_y)) * PROD_W'($signed(in_item.normal_y));
    dp_r[2]  <= PROD_W'($signed(in_item.ref_a_z)) * PROD_W'($signed(in_item.normal_z));
    a_item_r <= in_item;
  end

  // stage b: reference choice
  logic signed [DOT_W-1:0] dot;
  logic [DOT_W-1:0]        adot;
  logic                    fb_nxt;
  logic                    b_vld_r;
  vec_t                    b_ref_r;
  side_t                   b_side_r;

  always_comb begin
    dot    = DOT_W'(rnd_prod(dp_r[0])) + DOT_W'(rnd_prod(dp_r[1]))
           + DOT_W'(rnd_prod(dp_r[2]));
    adot   = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
    fb_nxt = adot > DOT_W'(swap_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_ref_r           <= fb_nxt ? {a_item_r.ref_b_z, a_item_r.ref_b_y, a_item_r.ref_b_x}
                                : {a_item_r.ref_a_z, a_item_r.ref_a_y, a_item_r.ref_a_x};
    b_side_r.nrm      <= {a_item_r.normal_z, a_item_r.normal_y, a_item_r.normal_x};
    b_side_r.tan1     <= '0;
    b_side_r.fallback <= fb_nxt;
    b_side_r.deg      <= 1'b0;
  end

  // first tangent
  logic            x1_vld, q1_vld, d1_vld;
  crossv_t         x1_c, q1_c;
  logic [SQ_W-1:0] x1_sq, q1_sq;
  side_t           x1_side, q1_side, d1_side, t2_side;
  logic [ROOT_W-1:0] q1_mag;
  vec_t            d1_t;

  tfn_cross u_cross1 (
    .clk(clk), .rst_n(rst_n), .in_valid(b_vld_r), .in_u(b_ref_r), .in_v(b_side_r.nrm),
    .in_side(b_side_r), .min_sq(minsq_r), .out_valid(x1_vld), .out_c(x1_c),
    .out_sq(x1_sq), .out_side(x1_side)
  );

  tfn_isqrt u_sqrt1 (
    .clk(clk), .rst_n(rst_n), .in_valid(x1_vld), .in_sq(x1_sq), .in_c(x1_c),
    .in_side(x1_side), .out_valid(q1_vld), .out_mag(q1_mag), .out_sq(q1_sq),
    .out_c(q1_c), .out_side(q1_side)
  );

  tfn_div u_div1 (
    .clk(clk), .rst_n(rst_n), .in_valid(q1_vld), .in_mag(q1_mag), .in_c(q1_c),
    .in_side(q1_side), .out_valid(d1_vld), .out_t(d1_t), .out_side(d1_side)
  );

  // carry the first tangent into the second pass
  always_comb begin
    t2_side      = d1_side;
    t2_side.tan1 = d1_t;
  end

  // second tangent
  logic            x2_vld, q2_vld, d2_vld;
  crossv_t         x2_c, q2_c;
  logic [SQ_W-1:0] x2_sq, q2_sq;
  side_t           x2_side, q2_side, d2_side;
  logic [ROOT_W-1:0] q2_mag;
  vec_t            d2_t;

  tfn_cross u_cross2 (
    .clk(clk), .rst_n(rst_n), .in_valid(d1_vld), .in_u(d1_side.nrm), .in_v(d1_t),
    .in_side(t2_side), .min_sq(minsq_r), .out_valid(x2_vld), .out_c(x2_c),
    .out_sq(x2_sq), .out_side(x2_side)
  );

  tfn_isqrt u_sqrt2 (
    .clk(clk), .rst_n(rst_n), .in_valid(x2_vld), .in_sq(x2_sq), .in_c(x2_c),
    .in_side(x2_side), .out_valid(q2_vld), .out_mag(q2_mag), .out_sq(q2_sq),
    .out_c(q2_c), .out_side(q2_side)
  );

  tfn_div u_div2 (
    .clk(clk), .rst_n(rst_n), .in_valid(q2_vld), .in_mag(q2_mag), .in_c(q2_c),
    .in_side(q2_side), .out_valid(d2_vld), .out_t(d2_t), .out_side(d2_side)
  );

  // output register, zeros on a degenerate item
  logic     out_strobe_r;
  tfn_out_t out_item_r, out_item_nxt;

  always_comb begin
    out_item_nxt.tan1_x        = d2_side.deg ? '0 : d2_side.tan1[0];
    out_item_nxt.tan1_y        = d2_side.deg ? '0 : d2_side.tan1[1];
    out_item_nxt.tan1_z        = d2_side.deg ? '0 : d2_side.tan1[2];
    out_item_nxt.tan2_x        = d2_side.deg ? '0 : d2_t[0];
    out_item_nxt.tan2_y        = d2_side.deg ? '0 : d2_t[1];
    out_item_nxt.tan2_z        = d2_side.deg ? '0 : d2_t[2];
    out_item_nxt.degenerate    = d2_side.deg;
    out_item_nxt.used_fallback = d2_side.fallback;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `TFN_ASSERT_NXT(a_swap_write, clk, rst_n, cfg_wr && (paddr[2] == CFG_SWAP_IDX),
    swap_r == $past(pwdata[REG_W-1:0]))
  `TFN_ASSERT_NXT(a_minsq_follow, clk, rst_n, 1'b1,
    minsq_r == MINSQ_W'($past(minmag_r)) * MINSQ_W'($past(minmag_r)))

endmodule

`default_nettype wire

[sv/tfn_cross.sv]
// tfn_cross: four-stage cross product, squared magnitude and small-magnitude flag
// depends on tfn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tfn_cross (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  tfn_pkg::vec_t                 in_u,
  input  tfn_pkg::vec_t                 in_v,
  input  tfn_pkg::side_t                in_side,
  input  logic [tfn_pkg::MINSQ_W-1:0]   min_sq,
  output logic                          out_valid,
  output tfn_pkg::crossv_t              out_c,
  output logic [tfn_pkg::SQ_W-1:0]      out_sq,
  output tfn_pkg::side_t                out_side
);
  import tfn_pkg::*;

  logic                     s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic signed [PROD_W-1:0] prod_r [6];
  side_t                    s1_side_r, s2_side_r, s3_side_r, s4_side_r;
  side_t                    side_nxt;
  crossv_t                  c_nxt, s2_c_r, s3_c_r, s4_c_r;
  logic [2:0][ABS_W-1:0]    abs_nxt, abs_r;
  logic [2:0][2*ABS_W-1:0]  sqr_r;
  logic [SQ_W-1:0]          sum_nxt, sum_r;
  logic                     deg_nxt;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // rounded differences and their magnitudes
  always_comb begin
    c_nxt[0] = CROSS_W'(rnd_prod(prod_r[0])) - CROSS_W'(rnd_prod(prod_r[1]));
    c_nxt[1] = CROSS_W'(rnd_prod(prod_r[2])) - CROSS_W'(rnd_prod(prod_r[3]));
    c_nxt[2] = CROSS_W'(rnd_prod(prod_r[4])) - CROSS_W'(rnd_prod(prod_r[5]));
    for (int i = 0; i < 3; i++) begin
      abs_nxt[i] = c_nxt[i][CROSS_W-1] ? ABS_W'(-c_nxt[i]) : ABS_W'(c_nxt[i]);
    end
  end

  // sum of squares and degenerate test
  always_comb begin
    sum_nxt = SQ_W'(sqr_r[0]) + SQ_W'(sqr_r[1]) + SQ_W'(sqr_r[2]);
    deg_nxt = (sum_nxt == '0) || (sum_nxt < SQ_W'(min_sq));
    side_nxt     = s3_side_r;
    side_nxt.deg = s3_side_r.deg | deg_nxt;
  end

  // payload stages
  always_ff @(posedge clk) begin
    prod_r[0] <= PROD_W'($signed(in_u[1])) * PROD_W'($signed(in_v[2]));
    prod_r[1] <= PROD_W'($signed(in_u[2])) * PROD_W'($signed(in_v[1]));
    prod_r[2] <= PROD_W'($signed(in_u[2])) * PROD_W'($signed(in_v[0]));
    prod_r[3] <= PROD_W'($signed(in_u[0])) * PROD_W'($signed(in_v[2]));
    prod_r[4] <= PROD_W'($signed(in_u[0])) * PROD_W'($signed(in_v[1]));
    prod_r[5] <= PROD_W'($signed(in_u[1])) * PROD_W'($signed(in_v[0]));
    s1_side_r <= in_side;
    s2_c_r    <= c_nxt;
    abs_r     <= abs_nxt;
    s2_side_r <= s1_side_r;
    for (int i = 0; i < 3; i++) begin
      sqr_r[i] <= (2*ABS_W)'(abs_r[i]) * (2*ABS_W)'(abs_r[i]);
    end
    s3_c_r    <= s2_c_r;
    s3_side_r <= s2_side_r;
    sum_r     <= sum_nxt;
    s4_c_r    <= s3_c_r;
    s4_side_r <= side_nxt;
  end

  assign out_valid = s4_vld_r;
  assign out_c     = s4_c_r;
  assign out_sq    = sum_r;
  assign out_side  = s4_side_r;

  `TFN_ASSERT_IMP(a_zero_sq_deg, clk, rst_n, out_valid && (out_sq == '0), out_side.deg)

endmodule

`default_nettype wire

[sv/tfn_isqrt.sv]
// tfn_isqrt: pipelined integer square root, one result bit per stage
// depends on tfn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tfn_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [tfn_pkg::SQ_W-1:0]      in_sq,
  input  tfn_pkg::crossv_t              in_c,
  input  tfn_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [tfn_pkg::ROOT_W-1:0]    out_mag,
  output logic [tfn_pkg::SQ_W-1:0]      out_sq,
  output tfn_pkg::crossv_t              out_c,
  output tfn_pkg::side_t                out_side
);
  import tfn_pkg::*;

  logic            vld_r  [ROOT_W];
  logic [SQ_W-1:0] rem_r  [ROOT_W];
  logic [SQ_W-1:0] root_r [ROOT_W];
  logic [SQ_W-1:0] sq_r   [ROOT_W];
  crossv_t         c_r    [ROOT_W];
  side_t           side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [SQ_W-1:0] TRIAL_BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
    logic            vld_in;
    logic [SQ_W-1:0] rem_in, root_in, sq_in, rem_nxt, root_nxt;
    logic [SQ_W:0]   trial;
    crossv_t         c_in;
    side_t           side_in;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_sq;
      assign root_in = '0;
      assign sq_in   = in_sq;
      assign c_in    = in_c;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sq_in   = sq_r[k-1];
      assign c_in    = c_r[k-1];
      assign side_in = side_r[k-1];
    end

    // one digit of the root
    assign trial = {1'b0, root_in} + {1'b0, TRIAL_BIT};
    always_comb begin
      if ({1'b0, rem_in} >= trial) begin
        rem_nxt  = rem_in - trial[SQ_W-1:0];
        root_nxt = (root_in >> 1) + TRIAL_BIT;
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      sq_r[k]   <= sq_in;
      c_r[k]    <= c_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_mag   = root_r[ROOT_W-1][ROOT_W-1:0];
  assign out_sq    = sq_r[ROOT_W-1];
  assign out_c     = c_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

  // root bounds check
  logic [SQ_W+1:0] lo_sq, hi_sq;
  assign lo_sq = (SQ_W + 2)'(out_mag) * (SQ_W + 2)'(out_mag);
  assign hi_sq = ((SQ_W + 2)'(out_mag) + 1'b1) * ((SQ_W + 2)'(out_mag) + 1'b1);

  `TFN_ASSERT_IMP(a_root_bound, clk, rst_n, out_valid,
    (lo_sq <= (SQ_W + 2)'(out_sq)) && (hi_sq > (SQ_W + 2)'(out_sq)))

endmodule

`default_nettype wire

[sv/tfn_div.sv]
// tfn_div: three-lane pipelined restoring divider giving rounded unit components
// depends on tfn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tfn_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [tfn_pkg::ROOT_W-1:0]    in_mag,
  input  tfn_pkg::crossv_t              in_c,
  input  tfn_pkg::side_t                in_side,
  output logic                          out_valid,
  output tfn_pkg::vec_t                 out_t,
  output tfn_pkg::side_t                out_side
);
  import tfn_pkg::*;

  logic                   pre_vld_r;
  logic [2:0][NUM_W-1:0]  pre_num_r, num_nxt;
  logic [ROOT_W-1:0]      pre_mag_r;
  logic [2:0]             pre_neg_r;
  side_t                  pre_side_r;
  logic [2:0][ABS_W-1:0]  abs_c;

  // numerators with half the divisor added for rounding
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_c[i]   = in_c[i][CROSS_W-1] ? ABS_W'(-in_c[i]) : ABS_W'(in_c[i]);
      num_nxt[i] = (NUM_W'(abs_c[i]) << FRAC_W) + NUM_W'(in_mag >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pre_num_r  <= num_nxt;
    pre_mag_r  <= in_mag;
    pre_side_r <= in_side;
    for (int i = 0; i < 3; i++) begin
      pre_neg_r[i] <= in_c[i][CROSS_W-1];
    end
  end

  logic                   vld_r  [QUO_W];
  logic [2:0][NUM_W-1:0]  rem_r  [QUO_W];
  logic [2:0][QUO_W-1:0]  quo_r  [QUO_W];
  logic [ROOT_W-1:0]      mag_r  [QUO_W];
  logic [2:0]             neg_r  [QUO_W];
  side_t                  side_r [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int SHIFT = QUO_W - 1 - j;
    logic                  vld_in;
    logic [2:0][NUM_W-1:0] rem_in, rem_nxt;
    logic [2:0][QUO_W-1:0] quo_in, quo_nxt;
    logic [ROOT_W-1:0]     mag_in;
    logic [2:0]            neg_in;
    side_t                 side_in;
    logic [NUM_W:0]        dsh;

    if (j == 0) begin : g_first
      assign vld_in  = pre_vld_r;
      assign rem_in  = pre_num_r;
      assign quo_in  = '0;
      assign mag_in  = pre_mag_r;
      assign neg_in  = pre_neg_r;
      assign side_in = pre_side_r;
    end else begin : g_next
      assign vld_in  = vld_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign mag_in  = mag_r[j-1];
      assign neg_in  = neg_r[j-1];
      assign side_in = side_r[j-1];
    end

    // one quotient bit in each lane
    assign dsh = (NUM_W + 1)'(mag_in) << SHIFT;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, rem_in[i]} >= dsh) begin
          rem_nxt[i] = rem_in[i] - NUM_W'(dsh);
          quo_nxt[i] = {quo_in[i][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = rem_in[i];
          quo_nxt[i] = {quo_in[i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= rem_nxt;
      quo_r[j]  <= quo_nxt;
      mag_r[j]  <= mag_in;
      neg_r[j]  <= neg_in;
      side_r[j] <= side_in;
    end
  end

  // apply the sign of the cross component
  logic [2:0][COMP_W-1:0] mag_q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_q[i] = COMP_W'(quo_r[QUO_W-1][i]);
      out_t[i] = neg_r[QUO_W-1][i] ? -mag_q[i] : mag_q[i];
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

  `TFN_ASSERT_IMP(a_unit_bound, clk, rst_n, out_valid && !out_side.deg,
    (mag_q[0] <= (COMP_W'(1) << FRAC_W)) && (mag_q[1] <= (COMP_W'(1) << FRAC_W))
      && (mag_q[2] <= (COMP_W'(1) << FRAC_W)))

endmodule

`default_nettype wire
